>>> hw/rtl/bcl_pkg.sv
// Shared types, constants and helpers for the breakpoint color interpolator.
`default_nettype none

package bcl_pkg;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  localparam logic [7:0] RAW_MAX    = 8'd255;
  localparam logic [6:0] LEVEL_ZERO = 7'd0;
  localparam logic [6:0] LEVEL_FULL = 7'd100;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Divider: |diff| (8b) * num (7b) fits 15 bits, one bit per step.
  localparam int unsigned DIV_LANES = 3;
  localparam int unsigned PROD_W    = 15;
  localparam int unsigned DIV_STEPS = PROD_W;

  // Channel 0 = red, 1 = green, 2 = blue.
  typedef logic [DIV_LANES-1:0][7:0] rgb_t;

  typedef struct packed {
    logic [6:0] level;
    rgb_t       rgb;
  } bp_entry_t;

  localparam int unsigned ENTRY_W = $bits(bp_entry_t);

  typedef struct packed {
    op_e        op;
    logic [2:0] idx;
    logic [6:0] level;  // breakpoint key, or percentage for a query
    rgb_t       rgb;
  } item_t;

  typedef struct packed {
    logic                             start;
    logic [6:0]                       den;
    logic [DIV_LANES-1:0][PROD_W-1:0] dvd;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    rgb_t                 quo;
    logic [DIV_LANES-1:0] rem_nz;
  } div_rsp_t;

  // round(raw*100/255) = (raw*100 + 127) / 255, with the divide done as
  // ((x + 1) * 257) >> 16, exact over this range.
  function automatic logic [6:0] percent_of(input logic [7:0] raw);
    logic [14:0] x1;
    logic [22:0] s;
    x1 = ({1'b0, raw, 6'b0} + {2'b0, raw, 5'b0}) + {5'b0, raw, 2'b0} + 15'd128;
    s  = {8'b0, x1} + {x1, 8'b0};
    return s[22:16];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bcl_ram #(
  parameter  int unsigned WIDTH = 31,
  parameter  int unsigned DEPTH = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/bcl_front.sv
// Front end: takes transactions, filters repeats and bad slots, queues work.
`default_nettype none

module bcl_front #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire logic           cmd_i,
  input  wire logic [2:0]     entry_index_i,
  input  wire logic [6:0]     entry_level_i,
  input  wire logic [7:0]     entry_red_i,
  input  wire logic [7:0]     entry_green_i,
  input  wire logic [7:0]     entry_blue_i,
  input  wire logic [9:0]     raw_brightness_i,
  output logic                item_avail_o,
  output bcl_pkg::item_t      item_o,
  input  wire logic           item_pop_i
);

  import bcl_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             last_valid_q, last_valid_d;
  logic [7:0]       last_raw_q, last_raw_d;

  logic [7:0] raw_clamped;
  logic       is_query, idx_ok, repeat_hit, keep, push;
  item_t      item_new;

  always_comb begin
    raw_clamped = (raw_brightness_i[9:8] != 2'b00) ? RAW_MAX : raw_brightness_i[7:0];
    is_query    = (cmd_i == OP_QUERY);
    idx_ok      = (32'(entry_index_i) < MAX_ENTRIES);
    repeat_hit  = last_valid_q && (raw_clamped == last_raw_q);
    keep        = is_query ? !repeat_hit : idx_ok;
    push        = start_i && !busy_o && keep;

    item_new.op    = op_e'(cmd_i);
    item_new.idx   = entry_index_i;
    item_new.level = is_query ? percent_of(raw_clamped) : entry_level_i;
    item_new.rgb   = {entry_blue_i, entry_green_i, entry_red_i};

    last_valid_d = last_valid_q;
    last_raw_d   = last_raw_q;
    if (push && is_query) begin
      last_valid_d = 1'b1;
      last_raw_d   = raw_clamped;
    end

    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = item_pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
      last_valid_q <= 1'b0;
      last_raw_q   <= '0;
    end else begin
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      count_q      <= count_d;
      last_valid_q <= last_valid_d;
      last_raw_q   <= last_raw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_new;
    end
  end

  assign busy_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign item_avail_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> hw/rtl/bcl_div.sv
// Three-lane restoring divider, one quotient bit per lane per cycle.
`default_nettype none

module bcl_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bcl_pkg::div_req_t req_i,
  output bcl_pkg::div_rsp_t   rsp_o
);

  import bcl_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic                             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [6:0]                       den_q, den_d;
  logic [DIV_LANES-1:0][6:0]        rem_q, rem_d;
  logic [DIV_LANES-1:0][PROD_W-1:0] dvd_q, dvd_d;
  rgb_t                             quo_q, quo_d;

  logic [7:0] trial;
  logic       ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    trial  = '0;
    ge     = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = req_i.den;
      rem_d  = '0;
      dvd_d  = req_i.dvd;
      quo_d  = '0;
    end else if (busy_q) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        trial    = {rem_q[l], dvd_q[l][PROD_W-1]};
        ge       = (trial >= {1'b0, den_q});
        rem_d[l] = ge ? 7'(trial - {1'b0, den_q}) : trial[6:0];
        dvd_d[l] = {dvd_q[l][PROD_W-2:0], 1'b0};
        // quotient stays below 256, upper bits shift out as zeros
        quo_d[l] = {quo_q[l][6:0], ge};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.quo  = quo_q;
    for (int l = 0; l < DIV_LANES; l++) begin
      rsp_o.rem_nz[l] = (rem_q[l] != '0);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bcl_back.sv
// Back end: table writes, breakpoint scan, interpolation and result strobe.
`default_nettype none

module bcl_back #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [3:0]     entry_count_i,
  input  wire logic           item_avail_i,
  input  wire bcl_pkg::item_t item_i,
  output logic                item_pop_o,
  output logic                result_valid_o,
  output logic [7:0]          out_red_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_blue_o
);

  import bcl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_DIV    = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        idx_q, idx_d, idx_nxt, n_entries;
  logic [6:0]           p_q, p_d;
  bp_entry_t            lo_q, lo_d, hi_q, hi_d;
  logic [DIV_LANES-1:0] neg_q, neg_d;
  logic                 valid_q, valid_d;
  rgb_t                 res_q, res_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  bp_entry_t            ram_wdata, ram_rdata;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic [6:0]           num, den;
  logic [7:0]           mag;

  bcl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bcl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (32'(entry_count_i) > MAX_ENTRIES) begin
      n_entries = CW'(MAX_ENTRIES);
    end else begin
      n_entries = CW'(entry_count_i);
    end
  end

  assign idx_nxt = idx_q + CW'(1);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    p_d       = p_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    neg_d     = neg_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    item_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(item_i.idx);
    ram_wdata = '{level: item_i.level, rgb: item_i.rgb};
    ram_re    = 1'b0;
    ram_raddr = '0;
    div_req   = '0;
    num       = p_q - lo_q.level;
    den       = hi_q.level - lo_q.level;
    mag       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (item_avail_i) begin
          item_pop_o = 1'b1;
          if (item_i.op == OP_LOAD) begin
            ram_we = 1'b1;
          end else begin
            p_d   = item_i.level;
            lo_d  = '{level: LEVEL_ZERO, rgb: '0};
            hi_d  = '{level: LEVEL_FULL, rgb: '0};
            idx_d = '0;
            if (n_entries != '0) begin
              ram_re  = 1'b1;
              state_d = S_SCAN;
            end else begin
              state_d = S_DECIDE;
            end
          end
        end
      end

      S_SCAN: begin
        if (ram_rdata.level == p_q) begin
          res_d   = ram_rdata.rgb;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (ram_rdata.level < p_q) begin
          lo_d = ram_rdata;
          if (idx_nxt < n_entries) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_nxt);
            idx_d     = idx_nxt;
          end else begin
            state_d = S_DECIDE;
          end
        end else begin
          hi_d    = ram_rdata;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (hi_q.level == LEVEL_FULL && lo_q.level == LEVEL_ZERO && lo_q.rgb == '0) begin
          res_d   = hi_q.rgb;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (hi_q.level == lo_q.level) begin
          res_d   = lo_q.rgb;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          div_req.start = 1'b1;
          div_req.den   = den;
          for (int c = 0; c < DIV_LANES; c++) begin
            neg_d[c]       = (lo_q.rgb[c] > hi_q.rgb[c]);
            mag            = neg_d[c] ? lo_q.rgb[c] - hi_q.rgb[c]
                                      : hi_q.rgb[c] - lo_q.rgb[c];
            div_req.dvd[c] = {7'b0, mag} * {8'b0, num};
          end
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          // falling channels round toward minus infinity
          for (int c = 0; c < DIV_LANES; c++) begin
            res_d[c] = neg_q[c]
                ? lo_q.rgb[c] - div_rsp.quo[c] - {7'b0, div_rsp.rem_nz[c]}
                : lo_q.rgb[c] + div_rsp.quo[c];
          end
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    neg_q <= neg_d;
  end

  assign result_valid_o = valid_q;
  assign out_red_o      = res_q[0];
  assign out_green_o    = res_q[1];
  assign out_blue_o     = res_q[2];

endmodule

`default_nettype wire

>>> hw/rtl/brightness_to_color_breakpoint_lerp.sv
// Top level of the brightness-to-color breakpoint interpolator.
//
// A transaction is taken on any clock edge with start high and busy low.
// cmd 0 writes one breakpoint (level and RGB) into the table; cmd 1 asks for
// the color of a raw brightness. A query whose clamped raw value repeats the
// previous query is dropped and gives no result; so does a load to a slot
// at or above MAX_ENTRIES. Every other query gives exactly one result,
// shown for a single cycle with result_valid_o high. The receiver cannot
// stall: a result must be captured in the cycle it is shown. Results come
// back in query order. Flow: the front end classifies a transaction in the
// cycle it arrives and drops it into a two-entry queue; busy is high only
// while that queue is full. The back end writes a load into the table as it
// pops it. A query leaves the queue, then reads the table one breakpoint
// at a time (one table read per cycle), and then either ends on an exact
// key match or a special case, or starts the bit-serial divider, which
// works the three channels side by side. The table itself has no reset;
// slots must be written before entry_count covers them. The user must
// write entry_count only while the block is idle; the block itself does
// not enforce it.

`default_nettype none

module brightness_to_color_breakpoint_lerp #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // command handshake
  input  wire logic       start,
  output logic            busy,
  input  wire logic       cmd_i,
  input  wire logic [2:0] entry_index_i,
  input  wire logic [6:0] entry_level_i,
  input  wire logic [7:0] entry_red_i,
  input  wire logic [7:0] entry_green_i,
  input  wire logic [7:0] entry_blue_i,
  input  wire logic [9:0] raw_brightness_i,
  // configuration: number of valid breakpoints
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  // result strobe
  output logic            result_valid_o,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o
);

  import bcl_pkg::*;

  logic [3:0] entry_count_q, entry_count_d;
  logic       item_avail, item_pop;
  item_t      item;

  assign entry_count_d = cfg_we_i ? cfg_wdata_i : entry_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else begin
      entry_count_q <= entry_count_d;
    end
  end

  // classify and queue
  bcl_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy),
    .cmd_i            (cmd_i),
    .entry_index_i    (entry_index_i),
    .entry_level_i    (entry_level_i),
    .entry_red_i      (entry_red_i),
    .entry_green_i    (entry_green_i),
    .entry_blue_i     (entry_blue_i),
    .raw_brightness_i (raw_brightness_i),
    .item_avail_o     (item_avail),
    .item_o           (item),
    .item_pop_i       (item_pop)
  );

  // table, scan and interpolation
  bcl_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_count_i  (entry_count_q),
    .item_avail_i   (item_avail),
    .item_i         (item),
    .item_pop_o     (item_pop),
    .result_valid_o (result_valid_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bcl_checker.sv
// Port-level checks for the interpolator top level, bound to it.
`default_nettype none

module bcl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       cmd_i,
  input wire logic [2:0] entry_index_i,
  input wire logic [6:0] entry_level_i,
  input wire logic [7:0] entry_red_i,
  input wire logic [7:0] entry_green_i,
  input wire logic [7:0] entry_blue_i,
  input wire logic [9:0] raw_brightness_i,
  input wire logic       cfg_we_i,
  input wire logic [3:0] cfg_wdata_i,
  input wire logic       result_valid_o,
  input wire logic [7:0] out_red_o,
  input wire logic [7:0] out_green_o,
  input wire logic [7:0] out_blue_o
);

  // Each query needs at least a scan or decide cycle: strobes never abut.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe high in two adjacent cycles");

  // The queue fills only by taking a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted transaction");

  // Result ports change only together with a strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(out_red_o) || !$stable(out_green_o) || !$stable(out_blue_o))
      |-> result_valid_o)
    else $error("result changed without strobe");

endmodule

bind brightness_to_color_breakpoint_lerp bcl_checker u_checker (.*);

`default_nettype wire

>>> sim/brightness_to_color_breakpoint_lerp_tb.sv
// Self-checking testbench for the brightness-to-color breakpoint interpolator.

module brightness_to_color_breakpoint_lerp_tb;
  import bcl_pkg::*;

  // Run limit in clock cycles, set well above the slowest legal run: about
  // 900 transactions, each with a random gap and its block time, plus the
  // idle waits around each entry_count write.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned PHASE_ITEMS = 85;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       cmd_i;
  logic [2:0] entry_index_i;
  logic [6:0] entry_level_i;
  logic [7:0] entry_red_i;
  logic [7:0] entry_green_i;
  logic [7:0] entry_blue_i;
  logic [9:0] raw_brightness_i;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       result_valid_o;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;

  brightness_to_color_breakpoint_lerp #(
    .MAX_ENTRIES(NUM_SLOTS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .entry_index_i   (entry_index_i),
    .entry_level_i   (entry_level_i),
    .entry_red_i     (entry_red_i),
    .entry_green_i   (entry_green_i),
    .entry_blue_i    (entry_blue_i),
    .raw_brightness_i(raw_brightness_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o)
  );

  // Shadow copy of the block state, kept in step with accepted transactions.
  bp_entry_t   shadow_table [NUM_SLOTS];
  logic [3:0]  shadow_count;
  bit          seen_valid;
  logic [7:0]  seen_raw;

  // Colors still owed by the block, oldest first.
  rgb_t        expected_colors [$];
  int unsigned error_count;
  int unsigned cycle_count;
  logic [9:0]  last_raw_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or never drains.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Color the block must return for a query, or 0 when the query is dropped
  // because its clamped raw value repeats the previous one. Updates the
  // last-query state exactly as the block does.
  function automatic bit color_for_query(input logic [9:0] raw_in, output rgb_t color);
    logic [7:0] raw;
    int pct, n, i, k, lo_lvl, hi_lvl, num, den, prod, q, mixed;
    rgb_t lo_c, hi_c;
    bit hit, done;
    raw = (raw_in > 10'(RAW_MAX)) ? RAW_MAX : raw_in[7:0];
    if (seen_valid && raw == seen_raw) return 1'b0;
    seen_raw   = raw;
    seen_valid = 1'b1;
    pct = (int'(raw) * 100 + 127) / 255;
    // entry_count above the table size scans the whole table
    n = (shadow_count > NUM_SLOTS) ? NUM_SLOTS : int'(shadow_count);
    lo_lvl = 0;
    hi_lvl = 100;
    lo_c   = '0;
    hi_c   = '0;
    color  = '0;
    hit    = 1'b0;
    done   = 1'b0;
    for (i = 0; i < n && !done; i++) begin
      if (int'(shadow_table[i].level) == pct) begin
        color = shadow_table[i].rgb;
        hit   = 1'b1;
        done  = 1'b1;
      end else if (int'(shadow_table[i].level) < pct) begin
        lo_lvl = int'(shadow_table[i].level);
        lo_c   = shadow_table[i].rgb;
      end else begin
        hi_lvl = int'(shadow_table[i].level);
        hi_c   = shadow_table[i].rgb;
        done   = 1'b1;
      end
    end
    if (!hit) begin
      if (hi_lvl == 100 && lo_lvl == 0 && lo_c == '0) begin
        // black floor at level 0: take the upper color as is
        color = hi_c;
      end else if (hi_lvl == lo_lvl) begin
        color = lo_c;
      end else begin
        num = pct - lo_lvl;
        den = hi_lvl - lo_lvl;
        for (k = 0; k < 3; k++) begin
          prod = (int'(hi_c[k]) - int'(lo_c[k])) * num;
          // floor division, also for a falling channel
          q = (prod >= 0) ? prod / den : -((-prod + den - 1) / den);
          mixed = int'(lo_c[k]) + q;
          color[k] = mixed[7:0];
        end
      end
    end
    return 1'b1;
  endfunction

  // Result checker: every strobe must match the oldest owed color.
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d",
                 $time, out_red_o, out_green_o, out_blue_o);
        error_count++;
      end else begin
        want = expected_colors.pop_front();
        if (out_red_o !== want[0]) begin
          $display("%0t: red mismatch, expected %0d, actual %0d", $time, want[0], out_red_o);
          error_count++;
        end
        if (out_green_o !== want[1]) begin
          $display("%0t: green mismatch, expected %0d, actual %0d", $time, want[1],
                   out_green_o);
          error_count++;
        end
        if (out_blue_o !== want[2]) begin
          $display("%0t: blue mismatch, expected %0d, actual %0d", $time, want[2],
                   out_blue_o);
          error_count++;
        end
      end
    end
  end

  // Send one transaction and wait until the block takes it. start is left
  // high so that a back-to-back transaction follows without a dip.
  task automatic send_item(input op_e op, input logic [2:0] idx, input logic [6:0] lvl,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [9:0] raw);
    rgb_t color;
    @(negedge clk_i);
    start            = 1'b1;
    cmd_i            = op;
    entry_index_i    = idx;
    entry_level_i    = lvl;
    entry_red_i      = r;
    entry_green_i    = g;
    entry_blue_i     = b;
    raw_brightness_i = raw;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OP_LOAD) begin
      shadow_table[idx].level = lvl;
      shadow_table[idx].rgb   = {b, g, r};
    end else begin
      last_raw_sent = raw;
      if (color_for_query(raw, color)) expected_colors.push_back(color);
    end
  endtask

  task automatic send_load(input logic [2:0] idx, input logic [6:0] lvl,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_item(OP_LOAD, idx, lvl, r, g, b, 10'($urandom_range(0, 1023)));
  endtask

  // Fields of a query that the block ignores still get random values.
  task automatic send_query(input logic [9:0] raw);
    send_item(OP_QUERY, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), raw);
  endtask

  // Drop start for a number of cycles; cmd, index, level and raw go to noise meanwhile.
  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start            = 1'b0;
      cmd_i            = op_e'($urandom_range(0, 1));
      entry_index_i    = 3'($urandom_range(0, 7));
      entry_level_i    = 7'($urandom_range(0, 127));
      raw_brightness_i = 10'($urandom_range(0, 1023));
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // entry_count is only written with nothing in flight. Loads and dropped
  // queries leave no trace, so a fixed drain follows the last result.
  task automatic write_entry_count(input logic [3:0] value);
    @(negedge clk_i);
    start = 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 4'($urandom_range(0, 15));
    shadow_count = value;
  endtask

  // Empty table straight out of reset: every answer is black, repeats drop.
  task automatic test_empty_table();
    send_query(10'd0);
    send_query(10'd0);     // repeat, dropped
    send_query(10'd1023);  // clamps to 255
    send_query(10'd255);   // same clamped value, dropped
    send_query(10'd128);
  endtask

  // Fill every slot; colors hit both channel extremes, the last key is above 100.
  task automatic test_load_table();
    send_load(3'd0, 7'd0,   8'd0,   8'd0,   8'd0);
    send_load(3'd1, 7'd20,  8'd255, 8'd0,   8'd0);
    send_load(3'd2, 7'd40,  8'd0,   8'd255, 8'd0);
    send_load(3'd3, 7'd50,  8'd0,   8'd0,   8'd255);
    send_load(3'd4, 7'd60,  8'd255, 8'd255, 8'd255);
    send_load(3'd5, 7'd80,  8'd255, 8'd0,   8'd255);
    send_load(3'd6, 7'd100, 8'd0,   8'd255, 8'd255);
    send_load(3'd7, 7'd127, 8'd12,  8'd34,  8'd56);
  endtask

  // Exact key hits and interpolation with rising and falling channels.
  task automatic test_lookup();
    write_entry_count(4'd8);
    send_query(10'd127);   // 50 percent, exact key
    send_query(10'd64);    // 25 percent, between 20 and 40
    send_query(10'd0);     // exact key 0, black
    send_query(10'd255);   // exact key 100
    send_query(10'd230);   // 90 percent, between 80 and 100
    send_query(10'd700);   // clamps to 255, not a repeat of 230
  endtask

  // Count above the table size, a single black floor entry, a white floor,
  // and an upper key above 100.
  task automatic test_count_limits();
    write_entry_count(4'd15);
    send_query(10'd200);
    write_entry_count(4'd1);
    send_query(10'd100);   // black floor only: black
    send_load(3'd0, 7'd0, 8'd255, 8'd255, 8'd255);
    send_query(10'd50);    // white fading to black at 100
    send_load(3'd6, 7'd127, 8'd200, 8'd100, 8'd50);
    write_entry_count(4'd7);
    send_query(10'd250);   // between 80 and the key above 100
    write_entry_count(4'd0);
    send_query(10'd77);
  endtask

  task automatic random_load();
    logic [6:0] lvl;
    lvl = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 100)) : 7'($urandom_range(0, 127));
    send_load(3'($urandom_range(0, 7)), lvl, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Ascending keys (ties allowed), sometimes starting on a black floor.
  task automatic load_sorted_table();
    int lvl;
    int unsigned slot;
    lvl = $urandom_range(0, 10);
    for (slot = 0; slot < NUM_SLOTS; slot++) begin
      if (slot == 0 && $urandom_range(0, 3) == 0)
        send_load(3'd0, 7'd0, 8'd0, 8'd0, 8'd0);
      else
        send_load(slot[2:0], lvl[6:0], 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      lvl = lvl + $urandom_range(0, 25);
      if (lvl > 100) lvl = 100;
    end
  endtask

  // Phases of random traffic, each under its own entry_count.
  task automatic test_random();
    logic [3:0] phase_counts [10];
    int unsigned phase, n, roll;
    bit no_gaps;
    phase_counts = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd12, 4'd5, 4'd8, 4'd2};
    for (phase = 0; phase < 10; phase++) begin
      write_entry_count(phase_counts[phase]);
      no_gaps = ($urandom_range(0, 2) == 0);
      n = 0;
      if ($urandom_range(0, 1) == 1) begin
        load_sorted_table();
        n = NUM_SLOTS;
      end
      while (n < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) random_load();
        else if (roll < 37) send_query(last_raw_sent);          // repeat, dropped
        else if (roll < 50) send_query(10'($urandom_range(256, 1023)));
        else send_query(10'($urandom_range(0, 255)));
        n++;
        if (!no_gaps) hold_off(pick_gap());
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    cmd_i            = OP_LOAD;
    entry_index_i    = '0;
    entry_level_i    = '0;
    entry_red_i      = '0;
    entry_green_i    = '0;
    entry_blue_i     = '0;
    raw_brightness_i = '0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    shadow_count     = '0;
    seen_valid       = 1'b0;
    seen_raw         = '0;
    error_count      = 0;
    cycle_count      = 0;
    last_raw_sent    = '0;
    for (int i = 0; i < NUM_SLOTS; i++) shadow_table[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Table slots are all written before entry_count first covers them.
    test_empty_table();
    test_load_table();
    test_lookup();
    test_count_limits();
    test_random();

    @(negedge clk_i);
    start = 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
